// ===== hw/rtl/weo_pkg.sv =====
// ----------------------------------------------------------------------------
// weo_pkg
// Shared types, constants and the arctangent table for the odometry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package weo_pkg;

    localparam int WEO_CORDIC_STEPS = 24;
    localparam logic signed [33:0] WEO_CORDIC_GAIN = 34'sd652032874;

    localparam int WEO_CNT_W = 32;
    localparam int WEO_TIME_W = 24;
    localparam int WEO_POS_W = 48;
    localparam int WEO_HEAD_W = 32;
    localparam int WEO_CFG_W = 32;
    localparam int WEO_ACC_W = 80;

    localparam logic [0:0] WEO_REG_DIST = 1'b0;
    localparam logic [0:0] WEO_REG_GAIN = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL_L = 9'b000000010,
        ST_MUL_R = 9'b000000100,
        ST_CORD  = 9'b000001000,
        ST_MUL_X = 9'b000010000,
        ST_MUL_Y = 9'b000100000,
        ST_MUL_T = 9'b001000000,
        ST_MUL_E = 9'b010000000,
        ST_DONE  = 9'b100000000
    } weo_state_t;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] weo_atan(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                5'd31: r = 32'd0;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wheel_encoder_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_encoder_odometry_unit
// Differential drive odometry: bit-serial multiplies and an iterative CORDIC.
// ----------------------------------------------------------------------------
// operation: each timed word runs the wheel multiplies, the CORDIC rotation and
// the position and heading multiplies on the shared one-bit-per-cycle multiplier
// throughput: a new word is taken only in idle, once the last pose is in the
// output register, which waits while the output word is stalled; a word with
// zero elapsed time gives no output and leaves the unit idle
// reset: asynchronous, clears pose, last counts and configuration registers to zero
`default_nettype none

module wheel_encoder_odometry_unit
#(
    parameter int CORDIC_STEPS = weo_pkg::WEO_CORDIC_STEPS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [87:0]  s_axis_tdata,  // left_count, right_count, elapsed_us
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // pos_x, pos_y, heading
);
    import weo_pkg::*;

    localparam logic [5:0] LAST_STEP = 6'(CORDIC_STEPS - 1);

    weo_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [WEO_ACC_W-1:0] acc_reg, acc_next, mc_reg, mc_next, addend;
    logic [31:0] mb_reg, mb_next;
    logic msgn_reg, msgn_next;
    logic [31:0] dist_reg, dist_next, gain_reg, gain_next;
    logic [31:0] last_l_reg, last_l_next, last_r_reg, last_r_next;
    logic [31:0] in_l_reg, in_l_next, in_r_reg, in_r_next;
    logic [23:0] el_reg, el_next;
    logic signed [47:0] dl_reg, dl_next, dr_reg, dr_next;
    logic signed [47:0] px_reg, px_next, py_reg, py_next;
    logic [31:0] hd_reg, hd_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [32:0] z_reg, z_next;
    logic mv_reg, mv_next;
    logic [127:0] out_reg, out_next;
    logic signed [48:0] lr_sum, diff;
    logic signed [47:0] mean;
    logic signed [51:0] pos_sum;
    logic signed [47:0] pos_sat;
    logic mul_last, accept;
    logic [1:0] quad;
    logic [31:0] zq;
    logic [31:0] atan_v;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = out_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign lr_sum = 49'(dl_reg) + 49'(dr_reg);
    assign mean   = lr_sum[48:1];
    assign diff   = 49'(dr_reg) - 49'(dl_reg);

    assign addend   = mb_reg[0] ? mc_reg : '0;
    assign mul_last = (cnt_reg[4:0] == 5'd31);
    assign acc_next = (mul_last && msgn_reg) ? acc_reg - addend : acc_reg + addend;

    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    assign atan_v = weo_atan(cnt_reg[4:0]);

    assign quad = 2'((hd_reg + 32'h2000_0000) >> 30);
    assign zq   = hd_reg - {quad, 30'd0};

    // position update with saturation
    always_comb
    begin
        logic signed [49:0] inc;
        inc = acc_next[79:30];
        if (state_reg == ST_MUL_X)
            pos_sum = 52'(px_reg) + 52'(inc);
        else
            pos_sum = 52'(py_reg) + 52'(inc);
        if (pos_sum > 52'sh7FFF_FFFF_FFFF)
            pos_sat = 48'sh7FFF_FFFF_FFFF;
        else if (pos_sum < -52'sh8000_0000_0000)
            pos_sat = -48'sh8000_0000_0000;
        else
            pos_sat = pos_sum[47:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mc_next     = mc_reg;
        mb_next     = mb_reg;
        msgn_next   = msgn_reg;
        dist_next   = dist_reg;
        gain_next   = gain_reg;
        last_l_next = last_l_reg;
        last_r_next = last_r_reg;
        in_l_next   = in_l_reg;
        in_r_next   = in_r_reg;
        el_next     = el_reg;
        dl_next     = dl_reg;
        dr_next     = dr_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        hd_next     = hd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        mv_next     = mv_reg && !m_axis_tready;
        out_next    = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                WEO_REG_DIST: dist_next = cfg_data;
                WEO_REG_GAIN: gain_next = cfg_data;
                default: ;
            endcase
        end

        if (state_reg == ST_MUL_L || state_reg == ST_MUL_R || state_reg == ST_MUL_X ||
            state_reg == ST_MUL_Y || state_reg == ST_MUL_T || state_reg == ST_MUL_E)
        begin
            mc_next  = mc_reg << 1;
            mb_next  = mb_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tdata[87:64] != 24'd0)
                begin
                    in_l_next  = s_axis_tdata[31:0];
                    in_r_next  = s_axis_tdata[63:32];
                    el_next    = s_axis_tdata[87:64];
                    mc_next    = WEO_ACC_W'(signed'(s_axis_tdata[31:0] - last_l_reg));
                    mb_next    = dist_reg;
                    msgn_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                if (mul_last)
                begin
                    dl_next    = acc_next[63:16];
                    mc_next    = WEO_ACC_W'(signed'(in_r_reg - last_r_reg));
                    mb_next    = dist_reg;
                    cnt_next   = '0;
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R:
            begin
                if (mul_last)
                begin
                    dr_next  = acc_next[63:16];
                    z_next   = 33'(signed'(zq));
                    cnt_next = '0;
                    unique case (quad)
                        2'd0: begin x_next = WEO_CORDIC_GAIN;  y_next = '0; end
                        2'd1: begin x_next = '0; y_next = WEO_CORDIC_GAIN;  end
                        2'd2: begin x_next = -WEO_CORDIC_GAIN; y_next = '0; end
                        default: begin x_next = '0; y_next = -WEO_CORDIC_GAIN; end
                    endcase
                    state_next = ST_CORD;
                end
            end
            ST_CORD:
            begin
                if (!z_reg[32])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - 33'(atan_v);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + 33'(atan_v);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    mc_next    = WEO_ACC_W'(mean);
                    mb_next    = x_next[31:0];
                    msgn_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                if (mul_last)
                begin
                    px_next    = pos_sat;
                    mc_next    = WEO_ACC_W'(mean);
                    mb_next    = y_reg[31:0];
                    cnt_next   = '0;
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y:
            begin
                if (mul_last)
                begin
                    py_next    = pos_sat;
                    mc_next    = WEO_ACC_W'(diff);
                    mb_next    = gain_reg;
                    msgn_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T:
            begin
                if (mul_last)
                begin
                    mc_next    = {16'd0, acc_next[63:0]};
                    mb_next    = {8'd0, el_reg};
                    cnt_next   = '0;
                    state_next = ST_MUL_E;
                end
            end
            ST_MUL_E:
            begin
                if (mul_last)
                begin
                    hd_next     = hd_reg + acc_next[63:32];
                    last_l_next = in_l_reg;
                    last_r_next = in_r_reg;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    out_next   = {hd_reg, py_reg, px_reg};
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            msgn_reg   <= 1'b0;
            dist_reg   <= '0;
            gain_reg   <= '0;
            last_l_reg <= '0;
            last_r_reg <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            hd_reg     <= '0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            msgn_reg   <= msgn_next;
            dist_reg   <= dist_next;
            gain_reg   <= gain_next;
            last_l_reg <= last_l_next;
            last_r_reg <= last_r_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            hd_reg     <= hd_next;
            mv_reg     <= mv_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE || (state_reg != ST_CORD && state_reg != ST_DONE && mul_last))
            acc_reg <= '0;
        else if (state_reg != ST_CORD && state_reg != ST_DONE)
            acc_reg <= acc_next;
        mc_reg   <= mc_next;
        mb_reg   <= mb_next;
        in_l_reg <= in_l_next;
        in_r_reg <= in_r_next;
        el_reg   <= el_next;
        dl_reg   <= dl_next;
        dr_reg   <= dr_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/weo_checker.sv =====
// ----------------------------------------------------------------------------
// weo_checker
// Port-level checks on the odometry unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module weo_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [87:0]  s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // a word with zero time is dropped and the unit stays ready
    a_zero_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[87:64] == 24'd0 |=> s_axis_tready)
        else $error("zero time word made the unit busy");

    // a timed word keeps the unit busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[87:64] != 24'd0 |=> !s_axis_tready)
        else $error("unit ready while working");

    // no output word straight after a timed input word
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[87:64] != 24'd0 && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("output word appeared too early");

endmodule

bind wheel_encoder_odometry_unit weo_checker u_weo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the odometry unit: streams encoder words through a
// bursty sender, predicts each pose word and compares it against the output
// while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import weo_pkg::*;

    localparam int LATENCY = 5 + 32 * 6 + WEO_CORDIC_STEPS;
    localparam int STALL_LIMIT = 20000;
    localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN = -64'sh8000_0000_0000;

    typedef struct packed {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] heading;
    } pose_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    // model state
    logic [31:0]        dist_per_tick;
    logic [31:0]        turn_gain;
    logic [31:0]        prev_left;
    logic [31:0]        prev_right;
    logic signed [63:0] pose_x;
    logic signed [63:0] pose_y;
    logic [31:0]        pose_heading;

    pose_t pending_poses[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    burst_left = 0;
    bit    hold_off = 1'b0;

    wheel_encoder_odometry_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [63:0] sat_pos(input logic signed [63:0] v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // floor(m * c / 2^30), full width product
    function automatic logic signed [63:0] scale_q30(input logic signed [63:0] m,
                                                     input logic signed [63:0] c);
        logic signed [127:0] p;
        p = 128'(m) * 128'(c);
        return 64'(p >>> 30);
    endfunction

    task automatic rotate_heading(input logic [31:0] angle,
                                  output logic signed [63:0] c,
                                  output logic signed [63:0] s);
        logic [1:0]         quad;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic [31:0]        folded;
        quad = 2'((angle + 32'h2000_0000) >> 30);
        folded = angle - {quad, 30'd0};
        z = 64'(signed'(folded));
        case (quad)
            2'd0: begin x = 64'(WEO_CORDIC_GAIN); y = 0; end
            2'd1: begin x = 0; y = 64'(WEO_CORDIC_GAIN); end
            2'd2: begin x = -64'(WEO_CORDIC_GAIN); y = 0; end
            default: begin x = 0; y = -64'(WEO_CORDIC_GAIN); end
        endcase
        for (int i = 0; i < WEO_CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - 64'(weo_atan(5'(i)));
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + 64'(weo_atan(5'(i)));
            end
        end
        c = x;
        s = y;
    endtask

    task automatic predict_pose(input logic [31:0] left, input logic [31:0] right,
                                input logic [23:0] elapsed);
        logic signed [63:0] dl;
        logic signed [63:0] dr;
        logic signed [63:0] mean;
        logic signed [63:0] diff;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic [127:0]       turn;
        pose_t              p;
        if (elapsed == 0)
            return;
        dl = (64'(signed'(left - prev_left)) * $signed({32'd0, dist_per_tick})) >>> 16;
        dr = (64'(signed'(right - prev_right)) * $signed({32'd0, dist_per_tick})) >>> 16;
        mean = (dl + dr) >>> 1;
        diff = dr - dl;
        rotate_heading(pose_heading, c, s);
        pose_x = sat_pos(pose_x + scale_q30(mean, c));
        pose_y = sat_pos(pose_y + scale_q30(mean, s));
        turn = {{64{diff[63]}}, diff} * {96'd0, turn_gain} * {104'd0, elapsed};
        pose_heading = pose_heading + turn[63:32];
        prev_left = left;
        prev_right = right;
        p.pos_x = pose_x[47:0];
        p.pos_y = pose_y[47:0];
        p.heading = pose_heading;
        pending_poses.push_back(p);
    endtask

    // valid stays high between words of one burst
    task automatic send_word(input logic [31:0] left, input logic [31:0] right,
                             input logic [23:0] elapsed);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        predict_pose(left, right, elapsed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {8'd0, elapsed, right, left};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == WEO_REG_DIST)
            dist_per_tick = val;
        else
            turn_gain = val;
    endtask

    task automatic test_directed;
        write_reg(WEO_REG_DIST, 32'h0100_0000);
        write_reg(WEO_REG_GAIN, 32'h0001_0000);
        send_word(32'd100, 32'd100, 24'd1);
        send_word(32'd200, 32'd300, 24'd0);
        send_word(32'd200, 32'd300, 24'd1000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd5);
        send_word(32'd0, 32'd0, 24'd5);
        drain();
        write_reg(WEO_REG_DIST, 32'hFFFF_FFFF);
        write_reg(WEO_REG_GAIN, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_word(32'h7FFF_0000 + 32'(i), 32'h7FFF_0000 * 32'(i), 24'hFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'd0, 24'd0);
        drain();
        write_reg(WEO_REG_DIST, 32'd0);
        write_reg(WEO_REG_GAIN, 32'd0);
        send_word(32'h1234_5678, 32'h8765_4321, 24'd7);
        drain();
    endtask

    task automatic test_random(input int count);
        logic [31:0] step_l;
        logic [31:0] step_r;
        for (int i = 0; i < count; i++)
        begin
            step_l = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000) - 2000;
            step_r = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000) - 2000;
            send_word(prev_left + step_l, prev_right + step_r,
                      $urandom_range(0, 7) == 0 ? 24'd0 : 24'($urandom()));
        end
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        fork
        begin
            repeat (3 * LATENCY) @(posedge clk);
            hold_off = 1'b0;
        end
        join_none
        test_random(6);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_poses.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    pose_t e;
                    pose_t a;
                    e = pending_poses.pop_front();
                    a = {m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tdata[127:96]};
                    if (a.pos_x !== e.pos_x)
                    begin
                        $display("%0t: pos_x exp %h got %h", $time, e.pos_x, a.pos_x);
                        errors++;
                    end
                    if (a.pos_y !== e.pos_y)
                    begin
                        $display("%0t: pos_y exp %h got %h", $time, e.pos_y, a.pos_y);
                        errors++;
                    end
                    if (a.heading !== e.heading)
                    begin
                        $display("%0t: heading exp %h got %h", $time, e.heading,
                                 a.heading);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0 || $time % 8000 > 4000);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("** wheel_encoder_odometry_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        dist_per_tick = 0;
        turn_gain = 0;
        prev_left = 0;
        prev_right = 0;
        pose_x = 0;
        pose_y = 0;
        pose_heading = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_reg(WEO_REG_DIST, 32'h0010_0000);
        write_reg(WEO_REG_GAIN, 32'h0000_4000);
        test_random(250);
        drain();
        test_backpressure();
        write_reg(WEO_REG_DIST, $urandom());
        write_reg(WEO_REG_GAIN, $urandom_range(0, 32'h0010_0000));
        test_random(280);
        drain();
        if (errors == 0)
            $display("** wheel_encoder_odometry_unit: PASSED **");
        else
            $display("** wheel_encoder_odometry_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/weo_pkg.sv
hw/rtl/wheel_encoder_odometry_unit.sv
hw/rtl/weo_checker.sv
verif/testbench.sv
